// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the plane registration cost engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons)
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons)
`endif
`endif

// ===== hw/rtl/prce_pkg.sv =====
// ----------------------------------------------------------------------------
// Plane registration cost engine package
// Types, sum layout and command encoding shared by controller and datapath.
// ----------------------------------------------------------------------------
package prce_pkg;

	localparam int OPND_W = 32;
	localparam int SUM_W  = 64;
	// Wide accumulator for exact evaluation sums.
	localparam int WIDE_W = 100;

	typedef logic [4:0] sum_addr_t;
	typedef logic [3:0] opnd_idx_t;
	typedef logic [3:0] res_idx_t;

	// Layout of the flattened sum register file.
	localparam sum_addr_t S_BASE  = 5'd0;
	localparam sum_addr_t MT_BASE = 5'd9;
	localparam sum_addr_t VR_BASE = 5'd18;
	localparam sum_addr_t VT_BASE = 5'd27;
	localparam sum_addr_t PP_ADDR = 5'd30;
	localparam sum_addr_t CP_ADDR = 5'd31;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;
	localparam logic [1:0] ACT_EVAL  = 2'd3;

	localparam res_idx_t RES_COST       = 4'd0;
	localparam res_idx_t RES_ROT_BASE   = 4'd1;
	localparam res_idx_t RES_TRANS_BASE = 4'd10;
	localparam res_idx_t RES_LAST       = 4'd12;

	typedef enum logic [2:0] {
		ASEL_OPND,
		ASEL_SUM_LO,
		ASEL_SUM_HI,
		ASEL_Q_LO,
		ASEL_Q_HI
	} asel_t;

	typedef enum logic {
		BSEL_OPND,
		BSEL_ROT
	} bsel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_SAT,
		ACC_W,
		ACC_C,
		ACC_GRAD,
		ACC_SUMC,
		ACC_COST
	} acc_t;

	typedef struct packed {
		logic      capture;
		logic      clear_sums;
		logic      load_rot;
		logic      mul_en;
		logic      clr_w;
		asel_t     a_sel;
		opnd_idx_t a_idx;
		bsel_t     b_sel;
		opnd_idx_t b_idx;
		sum_addr_t sum_addr;
		acc_t      acc;
		logic      hi;
		logic      dbl;
		logic      neg;
		res_idx_t  res_idx;
		logic      emit;
		logic      emit_last;
	} cmd_t;

endpackage

// ===== hw/rtl/plane_registration_cost_engine_top.sv =====
// ----------------------------------------------------------------------------
// Plane registration cost engine
// Accumulates a quadratic plane-correspondence cost and evaluates cost and
// gradients for a held rotation and a given translation.
// ----------------------------------------------------------------------------
//
// Channel    | Handshake          | Payload
// -----------+--------------------+-----------------------------------------
// command    | start / busy       | action, operand_0 .. operand_8
// result     | valid (one cycle)  | result_index, result_value, last
//
// A command transaction is taken at a rising edge with start high and busy low.
// Clear and load rotation hold busy for 1 cycle after the transaction.
// Add correspondence holds busy through 39 products, each a multiply step and
// a saturating accumulate step on the single shared 33x32 multiplier.
// Evaluate holds busy through 120 half-products of 64-bit sums or row terms
// against 32-bit operands (multiply, then accumulate), 12 gradient steps, 3 cost
// finishing steps, then 13 results on consecutive cycles, last on the final one.
// Reset is asynchronous and active low; it zeroes all sums and the held rotation.
// Results cannot be stalled; the receiver must take each one in its cycle.
//
module plane_registration_cost_engine_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] operand_0,
	input  logic signed [31:0] operand_1,
	input  logic signed [31:0] operand_2,
	input  logic signed [31:0] operand_3,
	input  logic signed [31:0] operand_4,
	input  logic signed [31:0] operand_5,
	input  logic signed [31:0] operand_6,
	input  logic signed [31:0] operand_7,
	input  logic signed [31:0] operand_8,
	output logic               valid,
	output logic [3:0]         result_index,
	output logic signed [63:0] result_value,
	output logic               last
);

	// Commands from the sequencer to the datapath, one word per cycle.
	prce_pkg::cmd_t cmd;

	// The controller walks the term loops; the datapath owns all arithmetic
	// and storage, including the result buffer that is replayed in index order.
	prce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd)
	);

	prce_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operand_0    (operand_0),
		.operand_1    (operand_1),
		.operand_2    (operand_2),
		.operand_3    (operand_3),
		.operand_4    (operand_4),
		.operand_5    (operand_5),
		.operand_6    (operand_6),
		.operand_7    (operand_7),
		.operand_8    (operand_8),
		.valid        (valid),
		.result_index (result_index),
		.result_value (result_value),
		.last         (last)
	);

endmodule

// ===== hw/rtl/prce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Plane registration cost engine controller
// Sequences the shared multiplier over correspondence and evaluation terms.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           action,
	output logic                 busy,
	output prce_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_LOAD,
		S_ADD_MUL,
		S_ADD_ACC,
		S_EV_MUL,
		S_EV_ACC,
		S_EV_GRAD,
		S_EV_PP,
		S_EV_CP,
		S_EV_COST,
		S_EMIT
	} state_t;

	localparam prce_pkg::opnd_idx_t OP_D1 = 4'd3;
	localparam prce_pkg::opnd_idx_t OP_N2 = 4'd4;
	localparam prce_pkg::opnd_idx_t OP_D2 = 4'd7;

	state_t             state_q;
	logic               busy_q;
	logic [1:0]         a_q;
	logic [1:0]         b_q;
	logic [1:0]         k_q;
	logic [1:0]         kind_q;
	logic [1:0]         stg_q;
	logic               trans_q;
	logic [3:0]         sub_q;
	prce_pkg::res_idx_t e_q;

	logic               accept;
	logic [3:0]         a3;
	logic [1:0]         bb;
	logic [3:0]         bb3;
	logic [3:0]         rk_idx;

	logic               ev_go;
	logic               ev_first;
	logic               emit_end;
	logic               idle_now;
	logic               add_end;
	logic               grad_now;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign a3     = {1'b0, a_q, 1'b0} + {2'b00, a_q};
	assign bb     = sub_q[2:1];
	assign bb3    = {1'b0, bb, 1'b0} + {2'b00, bb};
	assign rk_idx = a3 + {2'b00, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			kind_q  <= '0;
			stg_q   <= '0;
			trans_q <= 1'b0;
			sub_q   <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					a_q     <= '0;
					b_q     <= '0;
					k_q     <= '0;
					kind_q  <= '0;
					stg_q   <= '0;
					trans_q <= 1'b0;
					sub_q   <= '0;
					e_q     <= '0;
					if (accept) begin
						busy_q <= 1'b1;
						case (action)
							prce_pkg::ACT_CLEAR: state_q <= S_CLEAR;
							prce_pkg::ACT_ADD:   state_q <= S_ADD_MUL;
							prce_pkg::ACT_LOAD:  state_q <= S_LOAD;
							default:             state_q <= S_EV_MUL;
						endcase
					end
				end
				S_CLEAR, S_LOAD: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_ADD_MUL: begin
					state_q <= S_ADD_ACC;
				end
				S_ADD_ACC: begin
					state_q <= S_ADD_MUL;
					if (kind_q != 2'd2) begin
						kind_q <= kind_q + 2'd1;
					end else begin
						kind_q <= '0;
						case (stg_q)
							2'd0: begin
								if (b_q != 2'd2) begin
									b_q <= b_q + 2'd1;
								end else begin
									b_q <= '0;
									if (a_q != 2'd2) begin
										a_q <= a_q + 2'd1;
									end else begin
										a_q   <= '0;
										stg_q <= 2'd1;
									end
								end
							end
							2'd1: begin
								if (a_q != 2'd2) begin
									a_q <= a_q + 2'd1;
								end else begin
									a_q   <= '0;
									stg_q <= 2'd2;
								end
							end
							default: begin
								state_q <= S_IDLE;
								busy_q  <= 1'b0;
							end
						endcase
					end
				end
				S_EV_MUL: begin
					state_q <= S_EV_ACC;
				end
				S_EV_ACC: begin
					if (sub_q == 4'd5) begin
						sub_q   <= 4'd6;
						state_q <= S_EV_GRAD;
					end else if (sub_q == 4'd10) begin
						sub_q   <= '0;
						state_q <= S_EV_MUL;
						if (trans_q) begin
							if (a_q != 2'd2) begin
								a_q <= a_q + 2'd1;
							end else begin
								state_q <= S_EV_PP;
							end
						end else if (k_q != 2'd2) begin
							k_q <= k_q + 2'd1;
						end else begin
							k_q <= '0;
							if (a_q != 2'd2) begin
								a_q <= a_q + 2'd1;
							end else begin
								a_q     <= '0;
								trans_q <= 1'b1;
							end
						end
					end else begin
						sub_q   <= sub_q + 4'd1;
						state_q <= S_EV_MUL;
					end
				end
				S_EV_GRAD: begin
					sub_q   <= 4'd7;
					state_q <= S_EV_MUL;
				end
				S_EV_PP: begin
					state_q <= S_EV_CP;
				end
				S_EV_CP: begin
					state_q <= S_EV_COST;
				end
				S_EV_COST: begin
					e_q     <= prce_pkg::RES_COST;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (e_q == prce_pkg::RES_LAST) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						e_q <= e_q + 4'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Command decode from state and loop counters.
	always_comb begin
		cmd         = '0;
		cmd.a_sel   = prce_pkg::ASEL_OPND;
		cmd.b_sel   = prce_pkg::BSEL_OPND;
		cmd.acc     = prce_pkg::ACC_NONE;
		cmd.capture = (state_q == S_IDLE) && accept;
		case (state_q)
			S_CLEAR: cmd.clear_sums = 1'b1;
			S_LOAD:  cmd.load_rot = 1'b1;
			S_ADD_MUL, S_ADD_ACC: begin
				cmd.mul_en = (state_q == S_ADD_MUL);
				if (state_q == S_ADD_ACC) begin
					cmd.acc = prce_pkg::ACC_SAT;
				end
				case (stg_q)
					2'd0: begin
						case (kind_q)
							2'd0: begin
								cmd.a_idx    = {2'b00, a_q};
								cmd.b_idx    = {2'b00, b_q};
								cmd.sum_addr = prce_pkg::S_BASE + {1'b0, a3} + {3'b000, b_q};
							end
							2'd1: begin
								cmd.a_idx    = OP_N2 + {2'b00, a_q};
								cmd.b_idx    = OP_N2 + {2'b00, b_q};
								cmd.sum_addr = prce_pkg::MT_BASE + {1'b0, a3} + {3'b000, b_q};
							end
							default: begin
								cmd.a_idx    = {2'b00, a_q};
								cmd.b_idx    = OP_N2 + {2'b00, b_q};
								cmd.sum_addr = prce_pkg::VR_BASE + {1'b0, a3} + {3'b000, b_q};
								cmd.dbl      = 1'b1;
								cmd.neg      = 1'b1;
							end
						endcase
					end
					2'd1: begin
						case (kind_q)
							2'd0: begin
								cmd.a_idx    = OP_D2;
								cmd.b_idx    = OP_N2 + {2'b00, a_q};
								cmd.sum_addr = prce_pkg::VT_BASE + {3'b000, a_q};
								cmd.dbl      = 1'b1;
							end
							2'd1: begin
								cmd.a_idx    = OP_D1;
								cmd.b_idx    = OP_N2 + {2'b00, a_q};
								cmd.sum_addr = prce_pkg::VT_BASE + {3'b000, a_q};
								cmd.dbl      = 1'b1;
								cmd.neg      = 1'b1;
							end
							default: begin
								cmd.a_idx    = OP_N2 + {2'b00, a_q};
								cmd.b_idx    = OP_N2 + {2'b00, a_q};
								cmd.sum_addr = prce_pkg::PP_ADDR;
							end
						endcase
					end
					default: begin
						cmd.sum_addr = prce_pkg::CP_ADDR;
						case (kind_q)
							2'd0: begin
								cmd.a_idx = OP_D1;
								cmd.b_idx = OP_D1;
							end
							2'd1: begin
								cmd.a_idx = OP_D2;
								cmd.b_idx = OP_D2;
							end
							default: begin
								cmd.a_idx = OP_D1;
								cmd.b_idx = OP_D2;
								cmd.dbl   = 1'b1;
								cmd.neg   = 1'b1;
							end
						endcase
					end
				endcase
			end
			S_EV_MUL, S_EV_ACC, S_EV_GRAD: begin
				cmd.b_sel   = trans_q ? prce_pkg::BSEL_OPND : prce_pkg::BSEL_ROT;
				cmd.res_idx = trans_q ? (prce_pkg::RES_TRANS_BASE + {2'b00, a_q})
				                      : (prce_pkg::RES_ROT_BASE + rk_idx);
				if (sub_q < 4'd6) begin
					// Matrix-vector row term, low or high half of the sum.
					cmd.a_sel    = sub_q[0] ? prce_pkg::ASEL_SUM_HI : prce_pkg::ASEL_SUM_LO;
					cmd.hi       = sub_q[0];
					cmd.b_idx    = trans_q ? {2'b00, bb} : (bb3 + {2'b00, k_q});
					cmd.sum_addr = (trans_q ? prce_pkg::MT_BASE : prce_pkg::S_BASE)
					             + {1'b0, a3} + {3'b000, bb};
					cmd.clr_w    = (state_q == S_EV_MUL) && (sub_q == 4'd0);
				end else begin
					cmd.hi       = !sub_q[0];
					cmd.b_idx    = trans_q ? {2'b00, a_q} : rk_idx;
					cmd.sum_addr = trans_q ? (prce_pkg::VT_BASE + {3'b000, a_q})
					                       : (prce_pkg::VR_BASE + {1'b0, rk_idx});
					if (sub_q < 4'd9) begin
						cmd.a_sel = sub_q[0] ? prce_pkg::ASEL_Q_LO : prce_pkg::ASEL_Q_HI;
					end else begin
						cmd.a_sel = sub_q[0] ? prce_pkg::ASEL_SUM_LO : prce_pkg::ASEL_SUM_HI;
					end
				end
				cmd.mul_en = (state_q == S_EV_MUL);
				if (state_q == S_EV_ACC) begin
					cmd.acc = (sub_q < 4'd6) ? prce_pkg::ACC_W : prce_pkg::ACC_C;
				end else if (state_q == S_EV_GRAD) begin
					cmd.acc = prce_pkg::ACC_GRAD;
				end
			end
			S_EV_PP: begin
				cmd.acc      = prce_pkg::ACC_SUMC;
				cmd.sum_addr = prce_pkg::PP_ADDR;
			end
			S_EV_CP: begin
				cmd.acc      = prce_pkg::ACC_SUMC;
				cmd.sum_addr = prce_pkg::CP_ADDR;
			end
			S_EV_COST: begin
				cmd.acc     = prce_pkg::ACC_COST;
				cmd.res_idx = prce_pkg::RES_COST;
			end
			S_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.res_idx   = e_q;
				cmd.emit_last = (e_q == prce_pkg::RES_LAST);
			end
			default: begin
				cmd.capture = cmd.capture;
			end
		endcase
	end

	// Conditions checked by the assertions below.
	assign ev_go    = accept && (action == prce_pkg::ACT_EVAL);
	assign ev_first = (state_q == S_EV_MUL) && (sub_q == 4'd0) && !trans_q;
	assign emit_end = (state_q == S_EMIT) && (e_q == prce_pkg::RES_LAST);
	assign idle_now = (state_q == S_IDLE) && !busy_q;
	assign add_end  = (state_q == S_ADD_ACC) && (stg_q == 2'd2) && (kind_q == 2'd2);
	assign grad_now = (state_q == S_EV_GRAD);

	`ASSERT_NEXT(a_ev_start, clk, arst_n, ev_go, ev_first)
	`ASSERT_NEXT(a_emit_end, clk, arst_n, emit_end, idle_now)
	`ASSERT_IMPL(a_grad_order, clk, arst_n, grad_now, sub_q == 4'd6 && $past(state_q) == S_EV_ACC)
	`ASSERT_NEXT(a_add_done, clk, arst_n, add_end, idle_now)

endmodule

// ===== hw/rtl/prce_datapath.sv =====
// ----------------------------------------------------------------------------
// Plane registration cost engine datapath
// Shared multiplier, saturating sums, wide evaluation accumulators, results.
// ----------------------------------------------------------------------------
module prce_datapath #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  prce_pkg::cmd_t         cmd,
	input  logic signed [31:0]     operand_0,
	input  logic signed [31:0]     operand_1,
	input  logic signed [31:0]     operand_2,
	input  logic signed [31:0]     operand_3,
	input  logic signed [31:0]     operand_4,
	input  logic signed [31:0]     operand_5,
	input  logic signed [31:0]     operand_6,
	input  logic signed [31:0]     operand_7,
	input  logic signed [31:0]     operand_8,
	output logic                   valid,
	output logic [3:0]             result_index,
	output logic signed [63:0]     result_value,
	output logic                   last
);

	localparam int WW  = prce_pkg::WIDE_W;
	localparam int RSH = (2 * FRACTION_BITS >= 32) ? (2 * FRACTION_BITS - 32) : 0;
	localparam int LSH = (2 * FRACTION_BITS < 32) ? (32 - 2 * FRACTION_BITS) : 0;
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	logic signed [31:0] op_q  [9];
	logic signed [31:0] rot_q [9];
	logic signed [63:0] sum_q [32];
	logic signed [63:0] res_q [13];
	logic signed [64:0] prod_q;
	logic signed [WW-1:0] w_q;
	logic signed [WW-1:0] c_q;
	logic signed [63:0] q_q;
	logic               valid_q;
	logic [3:0]         ridx_q;
	logic signed [63:0] rval_q;
	logic               last_q;

	logic signed [63:0] sum_rd;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] p64;
	logic signed [63:0] scaled;
	logic signed [63:0] hi_bits;
	logic signed [63:0] twice;
	logic signed [63:0] term;
	logic signed [63:0] sum_new;
	logic signed [WW-1:0] prod_w;
	logic signed [WW-1:0] addend;
	logic signed [WW-1:0] sum_w;
	logic signed [WW-1:0] grad_in;

	function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
		if (v[64] != v[63]) begin
			return v[64] ? S64_MIN : S64_MAX;
		end
		return v[63:0];
	endfunction

	// Floor by 2^F, then saturate to 64 bits.
	function automatic logic signed [63:0] wout(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] sh;
		sh = v >>> FRACTION_BITS;
		if ((&sh[WW-1:63]) || !(|sh[WW-1:63])) begin
			return sh[63:0];
		end
		return sh[WW-1] ? S64_MIN : S64_MAX;
	endfunction

	assign sum_rd = sum_q[cmd.sum_addr];

	always_comb begin
		case (cmd.a_sel)
			prce_pkg::ASEL_SUM_LO: mul_a = {1'b0, sum_rd[31:0]};
			prce_pkg::ASEL_SUM_HI: mul_a = {sum_rd[63], sum_rd[63:32]};
			prce_pkg::ASEL_Q_LO:   mul_a = {1'b0, q_q[31:0]};
			prce_pkg::ASEL_Q_HI:   mul_a = {q_q[63], q_q[63:32]};
			default:               mul_a = {op_q[cmd.a_idx][31], op_q[cmd.a_idx]};
		endcase
		mul_b = (cmd.b_sel == prce_pkg::BSEL_ROT) ? rot_q[cmd.b_idx] : op_q[cmd.b_idx];
	end

	// Product scaling to Q32.32 and the saturating sum update.
	always_comb begin
		p64     = prod_q[63:0];
		hi_bits = p64 >>> (63 - LSH);
		if (2 * FRACTION_BITS >= 32) begin
			scaled = p64 >>> RSH;
		end else if ((hi_bits == 64'sd0) || (hi_bits == -64'sd1)) begin
			scaled = p64 <<< LSH;
		end else begin
			scaled = p64[63] ? S64_MIN : S64_MAX;
		end
		twice = sat65({scaled[63], scaled} + {scaled[63], scaled});
		term  = cmd.dbl ? twice : scaled;
		if (cmd.neg) begin
			sum_new = sat65({sum_rd[63], sum_rd} - {term[63], term});
		end else begin
			sum_new = sat65({sum_rd[63], sum_rd} + {term[63], term});
		end
	end

	always_comb begin
		prod_w  = {{(WW - 65){prod_q[64]}}, prod_q};
		addend  = cmd.hi ? (prod_w <<< 32) : prod_w;
		sum_w   = {{(WW - 64){sum_rd[63]}}, sum_rd} <<< FRACTION_BITS;
		grad_in = (w_q <<< 1) + sum_w;
	end

	// Architectural state with a defined reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				sum_q[i] <= '0;
			end
			for (int i = 0; i < 9; i++) begin
				rot_q[i] <= '0;
			end
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			last_q  <= cmd.emit_last;
			if (cmd.clear_sums) begin
				for (int i = 0; i < 32; i++) begin
					sum_q[i] <= '0;
				end
			end else if (cmd.acc == prce_pkg::ACC_SAT) begin
				sum_q[cmd.sum_addr] <= sum_new;
			end
			if (cmd.load_rot) begin
				for (int i = 0; i < 9; i++) begin
					rot_q[i] <= op_q[i];
				end
			end
		end
	end

	// Working registers and results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q[0] <= operand_0;
			op_q[1] <= operand_1;
			op_q[2] <= operand_2;
			op_q[3] <= operand_3;
			op_q[4] <= operand_4;
			op_q[5] <= operand_5;
			op_q[6] <= operand_6;
			op_q[7] <= operand_7;
			op_q[8] <= operand_8;
			c_q     <= '0;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.clr_w) begin
			w_q <= '0;
		end
		case (cmd.acc)
			prce_pkg::ACC_W:    w_q <= w_q + addend;
			prce_pkg::ACC_C:    c_q <= c_q + addend;
			prce_pkg::ACC_GRAD: begin
				res_q[cmd.res_idx] <= wout(grad_in);
				q_q                <= wout(w_q);
			end
			prce_pkg::ACC_SUMC: c_q <= c_q + sum_w;
			prce_pkg::ACC_COST: res_q[cmd.res_idx] <= wout(c_q);
			default: begin
				q_q <= q_q;
			end
		endcase
		if (cmd.emit) begin
			ridx_q <= cmd.res_idx;
			rval_q <= res_q[cmd.res_idx];
		end
	end

	assign valid        = valid_q;
	assign result_index = ridx_q;
	assign result_value = rval_q;
	assign last         = last_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane registration cost engine testbench
// Drives clear, add correspondence, load rotation and evaluate transactions,
// predicts the 13 evaluation results with a bit-exact software copy of the
// engine and checks every result transaction against it.
// ----------------------------------------------------------------------------
module tb;

	// Fraction bits of the operands; must match the block's parameter.
	localparam int FB = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 410;

	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] MONE = 32'hffff_0000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] action;
	logic signed [31:0] operand_0, operand_1, operand_2, operand_3, operand_4;
	logic signed [31:0] operand_5, operand_6, operand_7, operand_8;
	logic valid;
	logic [3:0] result_index;
	logic signed [63:0] result_value;
	logic last;

	plane_registration_cost_engine_top #(.FRACTION_BITS(FB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.operand_0(operand_0),
		.operand_1(operand_1),
		.operand_2(operand_2),
		.operand_3(operand_3),
		.operand_4(operand_4),
		.operand_5(operand_5),
		.operand_6(operand_6),
		.operand_7(operand_7),
		.operand_8(operand_8),
		.valid(valid),
		.result_index(result_index),
		.result_value(result_value),
		.last(last)
	);

	always #5 clk = ~clk;

	// One command transaction. When zero_exp is set, every evaluation result
	// is known to be zero and is typed in rather than taken from the model.
	typedef struct packed {
		logic [1:0]        act;
		logic              zero_exp;
		logic [0:8][31:0]  op;
	} cmd_row_t;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [63:0] value;
		logic               is_last;
	} grad_result_t;

	// Software copy of the engine's sums and held rotation.
	logic signed [63:0] outer_sum [9];
	logic signed [63:0] tquad_sum [9];
	logic signed [63:0] tlin_sum [3];
	logic signed [63:0] rlin_sum [9];
	logic signed [63:0] norm_sum;
	logic signed [63:0] dist_sum;
	logic signed [31:0] rot_held [9];

	grad_result_t pending_results [$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet_phase = 0;

	function automatic logic signed [127:0] wide(input logic signed [63:0] x);
		wide = x;
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [127:0] w);
		if (w > wide(64'sh7fff_ffff_ffff_ffff))
			return 64'sh7fff_ffff_ffff_ffff;
		if (w < wide(64'sh8000_0000_0000_0000))
			return 64'sh8000_0000_0000_0000;
		return w[63:0];
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp64(wide(a) + wide(b));
	endfunction

	function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp64(wide(a) - wide(b));
	endfunction

	// Operand product brought to 32 fraction bits.
	function automatic logic signed [63:0] prod_q32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [127:0] w;
		p = a * b;
		if (2 * FB >= 32)
			return p >>> (2 * FB - 32);
		w = p;
		w = w <<< (32 - 2 * FB);
		return clamp64(w);
	endfunction

	// Floor away the operand fraction bits and saturate to Q32.32.
	function automatic logic signed [63:0] floor_q32(input logic signed [127:0] w);
		return clamp64(w >>> FB);
	endfunction

	task automatic clear_model_sums();
		for (int k = 0; k < 9; k++) begin
			outer_sum[k] = '0;
			tquad_sum[k] = '0;
			rlin_sum[k] = '0;
		end
		for (int k = 0; k < 3; k++)
			tlin_sum[k] = '0;
		norm_sum = '0;
		dist_sum = '0;
	endtask

	task automatic add_correspondence(input logic [0:8][31:0] op);
		logic signed [31:0] n1 [3];
		logic signed [31:0] n2 [3];
		logic signed [31:0] d1, d2;
		logic signed [63:0] t;
		for (int k = 0; k < 3; k++) begin
			n1[k] = op[k];
			n2[k] = op[4 + k];
		end
		d1 = op[3];
		d2 = op[7];
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++) begin
				outer_sum[3*a+b] = add_sat(outer_sum[3*a+b], prod_q32(n1[a], n1[b]));
				tquad_sum[3*a+b] = add_sat(tquad_sum[3*a+b], prod_q32(n2[a], n2[b]));
				t = prod_q32(n1[a], n2[b]);
				rlin_sum[3*a+b] = sub_sat(rlin_sum[3*a+b], add_sat(t, t));
			end
		for (int a = 0; a < 3; a++) begin
			t = prod_q32(d2, n2[a]);
			tlin_sum[a] = add_sat(tlin_sum[a], add_sat(t, t));
			t = prod_q32(d1, n2[a]);
			tlin_sum[a] = sub_sat(tlin_sum[a], add_sat(t, t));
			norm_sum = add_sat(norm_sum, prod_q32(n2[a], n2[a]));
		end
		dist_sum = add_sat(dist_sum, prod_q32(d1, d1));
		dist_sum = add_sat(dist_sum, prod_q32(d2, d2));
		t = prod_q32(d1, d2);
		dist_sum = sub_sat(dist_sum, add_sat(t, t));
	endtask

	// Cost and gradients for the held rotation and translation tr; the
	// 13 results are queued in the order the block sends them.
	task automatic evaluate_cost(input logic [0:8][31:0] op, input logic zero_exp);
		logic signed [63:0] vals [13];
		logic signed [127:0] cost, g, gg, h, hh;
		logic signed [127:0] one_w;
		logic signed [31:0] tr [3];
		grad_result_t res;
		one_w = 128'sd1 <<< FB;
		cost = '0;
		for (int k = 0; k < 3; k++)
			tr[k] = op[k];
		for (int a = 0; a < 3; a++)
			for (int k = 0; k < 3; k++) begin
				g = '0;
				gg = '0;
				for (int b = 0; b < 3; b++) begin
					g += wide(outer_sum[3*a+b]) * wide(rot_held[3*b+k]);
					gg += wide(outer_sum[3*a+b]) * (wide(rot_held[3*b+k]) * 2);
				end
				gg += wide(rlin_sum[3*a+k]) * one_w;
				vals[1 + 3*a + k] = floor_q32(gg);
				cost += wide(floor_q32(g)) * wide(rot_held[3*a+k]);
				cost += wide(rlin_sum[3*a+k]) * wide(rot_held[3*a+k]);
			end
		for (int a = 0; a < 3; a++) begin
			h = '0;
			hh = '0;
			for (int b = 0; b < 3; b++) begin
				h += wide(tquad_sum[3*a+b]) * wide(tr[b]);
				hh += wide(tquad_sum[3*a+b]) * (wide(tr[b]) * 2);
			end
			hh += wide(tlin_sum[a]) * one_w;
			vals[10 + a] = floor_q32(hh);
			cost += wide(floor_q32(h)) * wide(tr[a]);
			cost += wide(tlin_sum[a]) * wide(tr[a]);
		end
		cost += wide(norm_sum) * one_w;
		cost += wide(dist_sum) * one_w;
		vals[0] = floor_q32(cost);
		for (int k = 0; k < 13; k++) begin
			res.idx = k[3:0];
			res.value = zero_exp ? 64'sd0 : vals[k];
			res.is_last = (prce_pkg::res_idx_t'(k) == prce_pkg::RES_LAST);
			pending_results.push_back(res);
		end
	endtask

	task automatic apply_to_model(input cmd_row_t row);
		case (row.act)
			prce_pkg::ACT_CLEAR: begin
				clear_model_sums();
			end
			prce_pkg::ACT_ADD: begin
				add_correspondence(row.op);
			end
			prce_pkg::ACT_LOAD: begin
				for (int k = 0; k < 9; k++)
					rot_held[k] = row.op[k];
			end
			default: begin
				evaluate_cost(row.op, row.zero_exp);
			end
		endcase
	endtask

	// Drive one command at the falling edge and hold it until the block takes
	// the transaction. A random burst of idle cycles may come first.
	task automatic send_command(input cmd_row_t row);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		action <= row.act;
		operand_0 <= row.op[0];
		operand_1 <= row.op[1];
		operand_2 <= row.op[2];
		operand_3 <= row.op[3];
		operand_4 <= row.op[4];
		operand_5 <= row.op[5];
		operand_6 <= row.op[6];
		operand_7 <= row.op[7];
		operand_8 <= row.op[8];
		do
			@(posedge clk);
		while (busy);
		// Predict at the accepting edge, before any result can show up.
		apply_to_model(row);
		@(negedge clk);
	endtask

	function automatic logic [31:0] sym_rand(input int unsigned mag);
		return $urandom_range(0, 2 * mag) - mag;
	endfunction

	function automatic cmd_row_t make_row(input logic [1:0] act, input int unsigned mag);
		cmd_row_t row;
		row.act = act;
		row.zero_exp = 1'b0;
		for (int k = 0; k < 9; k++)
			row.op[k] = sym_rand(mag);
		return row;
	endfunction

	// Directed part: extremes, every action, all-zero cases after reset and
	// after a clear, saturation of sums and results, and ignored operands.
	cmd_row_t directed [20] = '{
		'{prce_pkg::ACT_EVAL, 1'b1,
			'{MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV}},
		'{prce_pkg::ACT_LOAD, 1'b0,
			'{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV}},
		'{prce_pkg::ACT_EVAL, 1'b1,
			'{MINV, MAXV, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{ONE, 32'd0, 32'd0, 32'h0002_0000, 32'd0, ONE, 32'd0, MONE, 32'd0}},
		'{prce_pkg::ACT_EVAL, 1'b0, '{ONE, 32'h0002_0000, 32'h0003_0000, 32'd0, 32'd0,
			32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_LOAD, 1'b0,
			'{ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE}},
		'{prce_pkg::ACT_EVAL, 1'b0,
			'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}},
		'{prce_pkg::ACT_EVAL, 1'b0,
			'{MAXV, MAXV, MAXV, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, 32'd0}},
		'{prce_pkg::ACT_EVAL, 1'b0,
			'{MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}},
		'{prce_pkg::ACT_CLEAR, 1'b0,
			'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_EVAL, 1'b1,
			'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, MONE, 32'd0, 32'd0}},
		'{prce_pkg::ACT_ADD, 1'b0,
			'{ONE, ONE, 32'd0, MONE, 32'd0, ONE, ONE, ONE, MAXV}},
		'{prce_pkg::ACT_LOAD, 1'b0, '{32'h0000_8000, MONE, 32'd1, 32'hffff_ffff, ONE, 32'd0,
			32'h0001_8000, 32'd0, MONE}},
		'{prce_pkg::ACT_EVAL, 1'b0, '{32'h0005_4000, MONE, 32'hfff0_0000, 32'd0, 32'd0,
			32'd0, 32'd0, 32'd0, 32'd0}},
		'{prce_pkg::ACT_CLEAR, 1'b0,
			'{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV}},
		'{prce_pkg::ACT_EVAL, 1'b1,
			'{ONE, MONE, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}}
	};

	// Result checker: the block cannot stall results, so each strobe is one
	// result transaction and must match the oldest expectation.
	always @(posedge clk) begin
		grad_result_t exp_res;
		if (arst_n && valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result index %0d value %h", $time,
					result_index, result_value);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result_index !== exp_res.idx) begin
					$display("%0t: result_index expected %0d actual %0d", $time,
						exp_res.idx, result_index);
					errors++;
				end
				if (result_value !== exp_res.value) begin
					$display("%0t: result_value[%0d] expected %h actual %h", $time,
						exp_res.idx, exp_res.value, result_value);
					errors++;
				end
				if (last !== exp_res.is_last) begin
					$display("%0t: last[%0d] expected %b actual %b", $time,
						exp_res.idx, exp_res.is_last, last);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither a command nor a result
	// transaction takes place.
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL plane_registration_cost_engine_top");
			$finish;
		end
	end

	initial begin
		int sent;
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = prce_pkg::ACT_CLEAR;
		{operand_0, operand_1, operand_2, operand_3, operand_4} = '0;
		{operand_5, operand_6, operand_7, operand_8} = '0;
		clear_model_sums();
		for (int k = 0; k < 9; k++)
			rot_held[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_command(directed[i]);

		// Random part: mostly well-formed sequences (optional clear, a few
		// correspondences with unit-scale normals, a rotation, evaluations),
		// with full-range noise transactions mixed in.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent > RANDOM_ITEMS - 60)
				quiet_phase = 1;
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				send_command(make_row(2'($urandom_range(0, 3)), 32'h7fff_ffff));
				sent++;
			end else begin
				if ($urandom_range(0, 1))
					send_command(make_row(prce_pkg::ACT_CLEAR, 32'h7fff_ffff));
				repeat ($urandom_range(1, 6)) begin
					cmd_row_t row;
					row = make_row(prce_pkg::ACT_ADD, 32'h0002_0000);
					row.op[3] = sym_rand(32'h0014_0000);
					row.op[7] = sym_rand(32'h0014_0000);
					send_command(row);
					sent++;
				end
				send_command(make_row(prce_pkg::ACT_LOAD, 32'h0001_8000));
				repeat ($urandom_range(1, 3)) begin
					send_command(make_row(prce_pkg::ACT_EVAL, 32'h000a_0000));
					sent++;
				end
				sent += 2;
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("PASS plane_registration_cost_engine_top");
		else
			$display("FAIL plane_registration_cost_engine_top");
		$finish;
	end

endmodule

// ===== plane_registration_cost_engine_top.f =====
+incdir+hw/rtl
hw/rtl/prce_pkg.sv
hw/rtl/prce_ctrl.sv
hw/rtl/prce_datapath.sv
hw/rtl/plane_registration_cost_engine_top.sv
bench/tb.sv
